FILE: rtl/u8250_pkg.sv
// shared types and constants of the 8250-style uart register file
package u8250_pkg;

    // receive buffer geometry
    localparam int RX_DEPTH = 64;
    localparam int RX_AW    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int RX_CW    = $clog2(RX_DEPTH + 1);
    localparam logic [RX_CW-1:0] RX_FULL = RX_CW'(RX_DEPTH);

    // request kinds
    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_HOST  = 2'd2,
        KIND_BREAK = 2'd3
    } t_kind;

    // register offsets
    localparam logic [2:0] REG_RBR = 3'd0;
    localparam logic [2:0] REG_IER = 3'd1;
    localparam logic [2:0] REG_IIR = 3'd2;
    localparam logic [2:0] REG_LCR = 3'd3;
    localparam logic [2:0] REG_MCR = 3'd4;
    localparam logic [2:0] REG_LSR = 3'd5;
    localparam logic [2:0] REG_MSR = 3'd6;
    localparam logic [2:0] REG_SCR = 3'd7;

    // bit positions
    localparam int LSR_DR   = 0;
    localparam int LSR_BI   = 4;
    localparam int LSR_THRE = 5;
    localparam int LSR_TEMT = 6;
    localparam int LCR_DLAB = 7;
    localparam int MCR_LOOP = 4;
    localparam int FCR_CLR_RX = 1;
    localparam int FCR_CLR_TX = 2;
    localparam int IER_RDI  = 0;
    localparam int IER_THRI = 1;

    // interrupt identification codes
    localparam logic [3:0] IIR_NONE = 4'h1;
    localparam logic [3:0] IIR_THRI = 4'h2;
    localparam logic [3:0] IIR_RDI  = 4'h4;
    localparam logic [3:0] IIR_FIFO = 4'hC;

    // reset values and fixed reads
    localparam logic [7:0] MCR_RESET = 8'h08;
    localparam logic [7:0] LSR_RESET = 8'h60;
    localparam logic [7:0] MSR_CONST = 8'hB0;

endpackage

FILE: rtl/uart_8250_register_model.sv
// top level of the 8250-style uart register file
//
// Register file of an 8250-style UART. Each request is a bus write, a bus
// read, a received host byte or a break injection; every request yields
// exactly one result in the cycle after it is accepted, and a new request
// can be accepted every cycle unless the output is stalled. The control
// registers (divisor latch, IER, FCR, LCR, MCR, LSR, scratch, IIR) live in
// flops and are updated in the accept cycle; the 64-byte receive buffer is
// a synchronous RAM with one write and one read port. A bus read of the
// receive buffer issues its RAM read in the accept cycle and the data is
// muxed onto the result register's read data in the next cycle; a buffer
// write from one request lands in the RAM at its accept edge, so the next
// request always sees it and no forwarding is needed. The buffer is not
// cleared after reset: fill and read counters track which entries hold
// valid bytes. The result register holds while the output is stalled, and
// the input stalls only while a result is waiting and the output is
// stalled. The configuration port (break injection enable, reset 1) is
// always ready and should be written only while the block is idle.
module uart_8250_register_model (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data,
    // request channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_kind,
    input  logic [2:0] i_register_offset,
    input  logic [7:0] i_write_data,
    input  logic [7:0] i_host_byte,
    input  logic       i_burst_start,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_read_data,
    output logic       o_access_claimed,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_byte,
    output logic       o_rx_accepted,
    output logic       o_irq_level
);

    // architectural registers
    logic                        r_brk_en;
    logic [7:0]                  r_dll, r_dlm, r_fcr, r_lcr, r_mcr, r_lsr, r_scr;
    logic [3:0]                  r_ier, r_iir;
    logic                        r_irq;
    logic [u8250_pkg::RX_CW-1:0] r_rx_fill, r_rx_taken;

    logic [7:0]                  n_dll, n_dlm, n_fcr, n_lcr, n_mcr, n_lsr, n_scr;
    logic [3:0]                  n_ier, n_iir, n_id;
    logic                        n_irq;
    logic [u8250_pkg::RX_CW-1:0] n_rx_fill, n_rx_taken;

    // result stage
    logic       r_out_valid;
    logic [7:0] r_rd, r_tx;
    logic       r_claimed, r_txv, r_acc, r_irq_out, r_from_ram;

    // per-request combinational results
    logic       in_fire;
    logic       dlab, loopb, host_ok;
    logic [7:0] c_rd, c_tx;
    logic       c_claimed, c_txv, c_acc, c_from_ram;
    logic       c_we, c_re;
    logic [u8250_pkg::RX_AW-1:0] c_waddr, c_raddr;
    logic [7:0] c_wdata;
    logic [7:0] ram_rdata;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_fire     = i_in_valid && !o_in_stall;

    assign dlab  = r_lcr[u8250_pkg::LCR_DLAB];
    assign loopb = r_mcr[u8250_pkg::MCR_LOOP];

    always_comb begin
        n_dll      = r_dll;
        n_dlm      = r_dlm;
        n_ier      = r_ier;
        n_fcr      = r_fcr;
        n_lcr      = r_lcr;
        n_mcr      = r_mcr;
        n_lsr      = r_lsr;
        n_scr      = r_scr;
        n_rx_fill  = r_rx_fill;
        n_rx_taken = r_rx_taken;
        c_rd       = 8'h00;
        c_tx       = 8'h00;
        c_claimed  = 1'b0;
        c_txv      = 1'b0;
        c_acc      = 1'b0;
        c_from_ram = 1'b0;
        c_we       = 1'b0;
        c_re       = 1'b0;
        c_waddr    = r_rx_fill[u8250_pkg::RX_AW-1:0];
        c_wdata    = i_write_data;
        c_raddr    = r_rx_taken[u8250_pkg::RX_AW-1:0];
        host_ok    = 1'b0;

        case (u8250_pkg::t_kind'(i_kind))
            u8250_pkg::KIND_WRITE: begin
                c_claimed = 1'b1;
                unique case (i_register_offset)
                    u8250_pkg::REG_RBR: begin
                        if (dlab) begin
                            n_dll = i_write_data;
                        end else if (loopb) begin
                            // loopback: written byte goes to the receive buffer
                            if (r_rx_fill < u8250_pkg::RX_FULL) begin
                                c_we      = 1'b1;
                                n_rx_fill = r_rx_fill + u8250_pkg::RX_CW'(1);
                                n_lsr[u8250_pkg::LSR_DR] = 1'b1;
                            end
                        end else begin
                            // no transmit buffer: byte leaves at once
                            c_txv = 1'b1;
                            c_tx  = i_write_data;
                            n_lsr[u8250_pkg::LSR_TEMT] = 1'b1;
                            n_lsr[u8250_pkg::LSR_THRE] = 1'b1;
                        end
                    end
                    u8250_pkg::REG_IER: begin
                        if (dlab) begin
                            n_dlm = i_write_data;
                        end else begin
                            n_ier = i_write_data[3:0];
                        end
                    end
                    u8250_pkg::REG_IIR: n_fcr = i_write_data;
                    u8250_pkg::REG_LCR: n_lcr = i_write_data;
                    u8250_pkg::REG_MCR: n_mcr = i_write_data;
                    u8250_pkg::REG_SCR: n_scr = i_write_data;
                    default:            c_claimed = 1'b0;
                endcase
            end
            u8250_pkg::KIND_READ: begin
                c_claimed = 1'b1;
                unique case (i_register_offset)
                    u8250_pkg::REG_RBR: begin
                        if (dlab) begin
                            c_rd = r_dll;
                        end else if (r_rx_taken >= r_rx_fill ||
                                     r_rx_taken >= u8250_pkg::RX_FULL) begin
                            c_rd = 8'h00;
                        end else if (r_lsr[u8250_pkg::LSR_BI]) begin
                            // pending break reads as zero, byte stays
                            n_lsr[u8250_pkg::LSR_BI] = 1'b0;
                        end else begin
                            c_re       = 1'b1;
                            c_from_ram = 1'b1;
                            n_rx_taken = r_rx_taken + u8250_pkg::RX_CW'(1);
                            if (n_rx_taken >= r_rx_fill) begin
                                n_lsr[u8250_pkg::LSR_DR] = 1'b0;
                                n_rx_fill  = '0;
                                n_rx_taken = '0;
                            end
                        end
                    end
                    u8250_pkg::REG_IER: c_rd = dlab ? r_dlm : {4'h0, r_ier};
                    u8250_pkg::REG_IIR: c_rd = {u8250_pkg::IIR_FIFO, r_iir};
                    u8250_pkg::REG_LCR: c_rd = r_lcr;
                    u8250_pkg::REG_MCR: c_rd = r_mcr;
                    u8250_pkg::REG_LSR: c_rd = r_lsr;
                    u8250_pkg::REG_MSR: c_rd = u8250_pkg::MSR_CONST;
                    default:            c_rd = r_scr;
                endcase
            end
            u8250_pkg::KIND_HOST: begin
                // first byte of a burst needs an idle receiver
                if (i_burst_start) begin
                    host_ok = !r_lsr[u8250_pkg::LSR_DR] && r_rx_fill == '0;
                end else begin
                    host_ok = r_rx_fill != '0;
                end
                if (!loopb && host_ok && r_rx_fill < u8250_pkg::RX_FULL) begin
                    c_we      = 1'b1;
                    c_wdata   = i_host_byte;
                    n_rx_fill = r_rx_fill + u8250_pkg::RX_CW'(1);
                    n_lsr[u8250_pkg::LSR_DR] = 1'b1;
                    c_acc     = 1'b1;
                end
            end
            default: begin
                if (r_brk_en && i_host_byte != 8'h00 && !loopb &&
                    !r_lsr[u8250_pkg::LSR_DR] && r_rx_fill == '0) begin
                    c_we      = 1'b1;
                    c_waddr   = '0;
                    c_wdata   = i_host_byte;
                    n_rx_fill = u8250_pkg::RX_CW'(1);
                    n_lsr[u8250_pkg::LSR_DR] = 1'b1;
                    n_lsr[u8250_pkg::LSR_BI] = 1'b1;
                    c_acc     = 1'b1;
                end
            end
        endcase

        // fifo clear bits act once and clear themselves
        if (n_fcr[u8250_pkg::FCR_CLR_RX]) begin
            n_fcr[u8250_pkg::FCR_CLR_RX] = 1'b0;
            n_rx_fill  = '0;
            n_rx_taken = '0;
            n_lsr[u8250_pkg::LSR_DR] = 1'b0;
        end
        if (n_fcr[u8250_pkg::FCR_CLR_TX]) begin
            n_fcr[u8250_pkg::FCR_CLR_TX] = 1'b0;
            n_lsr[u8250_pkg::LSR_TEMT] = 1'b1;
            n_lsr[u8250_pkg::LSR_THRE] = 1'b1;
        end

        // interrupt identification
        n_id = 4'h0;
        if (n_ier[u8250_pkg::IER_RDI] && n_lsr[u8250_pkg::LSR_DR]) begin
            n_id = n_id | u8250_pkg::IIR_RDI;
        end
        if (n_ier[u8250_pkg::IER_THRI] && n_lsr[u8250_pkg::LSR_TEMT]) begin
            n_id = n_id | u8250_pkg::IIR_THRI;
        end
        n_iir = (n_id != 4'h0) ? n_id : u8250_pkg::IIR_NONE;
        n_irq = n_id != 4'h0;
        if (!n_ier[u8250_pkg::IER_THRI]) begin
            n_lsr[u8250_pkg::LSR_TEMT] = 1'b1;
            n_lsr[u8250_pkg::LSR_THRE] = 1'b1;
        end
    end

    // receive buffer
    u8250_ram #(
        .WIDTH (8),
        .DEPTH (u8250_pkg::RX_DEPTH),
        .AW    (u8250_pkg::RX_AW)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (in_fire && c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_re    (in_fire && c_re),
        .i_raddr (c_raddr),
        .o_rdata (ram_rdata)
    );

    // architectural state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brk_en   <= 1'b1;
            r_dll      <= 8'h00;
            r_dlm      <= 8'h00;
            r_ier      <= 4'h0;
            r_fcr      <= 8'h00;
            r_lcr      <= 8'h00;
            r_mcr      <= u8250_pkg::MCR_RESET;
            r_lsr      <= u8250_pkg::LSR_RESET;
            r_scr      <= 8'h00;
            r_iir      <= u8250_pkg::IIR_NONE;
            r_irq      <= 1'b0;
            r_rx_fill  <= '0;
            r_rx_taken <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_brk_en <= i_cfg_data;
            end
            if (in_fire) begin
                r_dll      <= n_dll;
                r_dlm      <= n_dlm;
                r_ier      <= n_ier;
                r_fcr      <= n_fcr;
                r_lcr      <= n_lcr;
                r_mcr      <= n_mcr;
                r_lsr      <= n_lsr;
                r_scr      <= n_scr;
                r_iir      <= n_iir;
                r_irq      <= n_irq;
                r_rx_fill  <= n_rx_fill;
                r_rx_taken <= n_rx_taken;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_rd       <= c_rd;
            r_claimed  <= c_claimed;
            r_txv      <= c_txv;
            r_tx       <= c_tx;
            r_acc      <= c_acc;
            r_irq_out  <= n_irq;
            r_from_ram <= c_from_ram;
        end
    end

    // buffer data holds until the next accepted read
    assign o_out_valid      = r_out_valid;
    assign o_read_data      = r_from_ram ? ram_rdata : r_rd;
    assign o_access_claimed = r_claimed;
    assign o_tx_valid       = r_txv;
    assign o_tx_byte        = r_tx;
    assign o_rx_accepted    = r_acc;
    assign o_irq_level      = r_irq_out;

    // fill count stays within the buffer
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rx_fill <= u8250_pkg::RX_FULL)
        else $error("receive fill count beyond buffer depth");

    // read pointer trails fill, both zero when empty
    a_taken_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rx_taken < r_rx_fill) || (r_rx_taken == '0 && r_rx_fill == '0))
        else $error("receive read pointer out of order");

    // data ready mirrors a nonempty buffer
    a_dr_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lsr[u8250_pkg::LSR_DR] == (r_rx_fill != '0))
        else $error("lsr data ready disagrees with buffer fill");

    // interrupt line agrees with identification
    a_irq_iir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_irq == (r_iir != u8250_pkg::IIR_NONE))
        else $error("irq level disagrees with iir");

    // a stalled result keeps its buffer data
    a_ram_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall && r_from_ram) |=> $stable(o_read_data))
        else $error("buffered read data changed while stalled");

endmodule

FILE: rtl/u8250_ram.sv
// generic single-port-write, registered-read ram
module u8250_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sim/tb_uart_8250_register_model.sv
// self-checking testbench of the 8250-style uart register file, with its own register predictor
`timescale 1ns / 100ps

module tb_uart_8250_register_model;

    // timing and pacing
    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int HOLD_CYCLES   = 48;     // long receiver hold-off at each phase start
    localparam int STUCK_LIMIT   = 2000;   // cycles without any handshake before giving up
    localparam int SETTLE_CYCLES = 4;      // extra settle time after the last reply
    localparam int RANDOM_ITEMS  = 275;    // random requests per pacing phase

    // register bit masks built from the package bit positions
    localparam logic [7:0] DLAB_MASK     = 8'(1 << u8250_pkg::LCR_DLAB);
    localparam logic [7:0] LOOP_MASK     = 8'(1 << u8250_pkg::MCR_LOOP);
    localparam logic [7:0] FLUSH_RX_MASK = 8'(1 << u8250_pkg::FCR_CLR_RX);
    localparam logic [7:0] FLUSH_TX_MASK = 8'(1 << u8250_pkg::FCR_CLR_TX);

    // buffer count helpers
    localparam int                         CW      = u8250_pkg::RX_CW;
    localparam int                         AW      = u8250_pkg::RX_AW;
    localparam logic [u8250_pkg::RX_CW-1:0] CNT_ONE = u8250_pkg::RX_CW'(1);

    typedef struct packed {
        u8250_pkg::t_kind kind;
        logic [2:0]       offset;
        logic [7:0]       wdata;
        logic [7:0]       hbyte;
        logic             burst_first;
    } t_uart_req;

    typedef struct packed {
        logic [7:0] read_data;
        logic       claimed;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_stored;
        logic       irq;
    } t_uart_reply;

    // every block input starts at a known value
    logic       i_clk             = 1'b0;
    logic       i_rst_n           = 1'b0;
    logic       i_cfg_valid       = 1'b0;
    logic       i_cfg_data        = 1'b0;
    logic       i_in_valid        = 1'b0;
    logic [1:0] i_kind            = '0;
    logic [2:0] i_register_offset = '0;
    logic [7:0] i_write_data      = '0;
    logic [7:0] i_host_byte       = '0;
    logic       i_burst_start     = 1'b0;
    logic       i_out_stall       = 1'b0;

    logic       o_cfg_ready;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_read_data;
    logic       o_access_claimed;
    logic       o_tx_valid;
    logic [7:0] o_tx_byte;
    logic       o_rx_accepted;
    logic       o_irq_level;

    // requests waiting for the driver, and predicted replies waiting for the block
    t_uart_req   req_backlog[$];
    t_uart_reply reply_q[$];
    t_uart_req   next_req;
    t_uart_req   seen_req;
    t_uart_reply got_rep;
    t_uart_reply want_rep;
    logic        req_taken = 1'b0;

    // pacing knobs, set by the sequencer at the start of each phase
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int phase_id      = 0;
    int held_phase    = 0;
    int hold_left     = 0;
    int stuck_cycles  = 0;

    // run statistics
    int mismatches = 0;
    int n_accepted = 0;
    int n_results  = 0;
    int n_stored   = 0;
    int n_sent     = 0;
    int n_irq      = 0;

    // predictor copy of the register file
    logic [7:0]    dll_m, dlm_m, fcr_m, lcr_m, mcr_m, lsr_m, scr_m;
    logic [3:0]    ier_m, iir_m;
    logic          irq_m, brk_en_m;
    logic [7:0]    rx_mem_m [u8250_pkg::RX_DEPTH];
    logic [CW-1:0] rx_fill_m, rx_rd_m;

    uart_8250_register_model dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_kind            (i_kind),
        .i_register_offset (i_register_offset),
        .i_write_data      (i_write_data),
        .i_host_byte       (i_host_byte),
        .i_burst_start     (i_burst_start),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_read_data       (o_read_data),
        .o_access_claimed  (o_access_claimed),
        .o_tx_valid        (o_tx_valid),
        .o_tx_byte         (o_tx_byte),
        .o_rx_accepted     (o_rx_accepted),
        .o_irq_level       (o_irq_level)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // applies one request to the predicted register file and returns the reply
    function automatic t_uart_reply model_apply(t_uart_req r);
        t_uart_reply rep;
        logic        dlab;
        logic        loop;
        logic        ok;
        logic [3:0]  cause;
        rep  = '0;
        dlab = lcr_m[u8250_pkg::LCR_DLAB];
        loop = mcr_m[u8250_pkg::MCR_LOOP];
        case (r.kind)
            u8250_pkg::KIND_WRITE: begin
                rep.claimed = 1'b1;
                case (r.offset)
                    u8250_pkg::REG_RBR: begin
                        if (dlab) begin
                            dll_m = r.wdata;
                        end else if (loop) begin
                            // loopback: byte goes into the receive buffer, dropped when full
                            if (rx_fill_m < u8250_pkg::RX_FULL) begin
                                rx_mem_m[rx_fill_m[AW-1:0]] = r.wdata;
                                rx_fill_m = rx_fill_m + CNT_ONE;
                                lsr_m[u8250_pkg::LSR_DR] = 1'b1;
                            end
                        end else begin
                            // no transmit buffer, the byte leaves at once
                            rep.tx_valid = 1'b1;
                            rep.tx_byte  = r.wdata;
                            lsr_m[u8250_pkg::LSR_TEMT] = 1'b1;
                            lsr_m[u8250_pkg::LSR_THRE] = 1'b1;
                        end
                    end
                    u8250_pkg::REG_IER: begin
                        if (dlab) begin
                            dlm_m = r.wdata;
                        end else begin
                            ier_m = r.wdata[3:0];
                        end
                    end
                    u8250_pkg::REG_IIR: fcr_m = r.wdata;
                    u8250_pkg::REG_LCR: lcr_m = r.wdata;
                    u8250_pkg::REG_MCR: mcr_m = r.wdata;
                    u8250_pkg::REG_SCR: scr_m = r.wdata;
                    default:            rep.claimed = 1'b0;
                endcase
            end
            u8250_pkg::KIND_READ: begin
                rep.claimed = 1'b1;
                case (r.offset)
                    u8250_pkg::REG_RBR: begin
                        if (dlab) begin
                            rep.read_data = dll_m;
                        end else if (rx_rd_m >= rx_fill_m) begin
                            rep.read_data = 8'h00;
                        end else if (lsr_m[u8250_pkg::LSR_BI]) begin
                            // pending break reads as zero and keeps the stored byte
                            lsr_m[u8250_pkg::LSR_BI] = 1'b0;
                        end else begin
                            rep.read_data = rx_mem_m[rx_rd_m[AW-1:0]];
                            rx_rd_m = rx_rd_m + CNT_ONE;
                            if (rx_rd_m >= rx_fill_m) begin
                                lsr_m[u8250_pkg::LSR_DR] = 1'b0;
                                rx_fill_m = '0;
                                rx_rd_m   = '0;
                            end
                        end
                    end
                    u8250_pkg::REG_IER: rep.read_data = dlab ? dlm_m : {4'h0, ier_m};
                    u8250_pkg::REG_IIR: rep.read_data = {u8250_pkg::IIR_FIFO, iir_m};
                    u8250_pkg::REG_LCR: rep.read_data = lcr_m;
                    u8250_pkg::REG_MCR: rep.read_data = mcr_m;
                    u8250_pkg::REG_LSR: rep.read_data = lsr_m;
                    u8250_pkg::REG_MSR: rep.read_data = u8250_pkg::MSR_CONST;
                    default:            rep.read_data = scr_m;
                endcase
            end
            u8250_pkg::KIND_HOST: begin
                if (r.burst_first) begin
                    ok = !lsr_m[u8250_pkg::LSR_DR] && (rx_fill_m == '0);
                end else begin
                    ok = (rx_fill_m != '0);
                end
                if (!loop && ok && rx_fill_m < u8250_pkg::RX_FULL) begin
                    rx_mem_m[rx_fill_m[AW-1:0]] = r.hbyte;
                    rx_fill_m = rx_fill_m + CNT_ONE;
                    lsr_m[u8250_pkg::LSR_DR] = 1'b1;
                    rep.rx_stored = 1'b1;
                end
            end
            default: begin
                if (brk_en_m && r.hbyte != 8'h00 && !loop && !lsr_m[u8250_pkg::LSR_DR]
                    && rx_fill_m == '0) begin
                    rx_mem_m[0] = r.hbyte;
                    rx_fill_m = CNT_ONE;
                    lsr_m[u8250_pkg::LSR_DR] = 1'b1;
                    lsr_m[u8250_pkg::LSR_BI] = 1'b1;
                    rep.rx_stored = 1'b1;
                end
            end
        endcase

        // self-clearing flush bits, then interrupt identification
        if (fcr_m[u8250_pkg::FCR_CLR_RX]) begin
            fcr_m[u8250_pkg::FCR_CLR_RX] = 1'b0;
            rx_fill_m = '0;
            rx_rd_m   = '0;
            lsr_m[u8250_pkg::LSR_DR] = 1'b0;
        end
        if (fcr_m[u8250_pkg::FCR_CLR_TX]) begin
            fcr_m[u8250_pkg::FCR_CLR_TX] = 1'b0;
            lsr_m[u8250_pkg::LSR_TEMT] = 1'b1;
            lsr_m[u8250_pkg::LSR_THRE] = 1'b1;
        end
        cause = 4'h0;
        if (ier_m[u8250_pkg::IER_RDI] && lsr_m[u8250_pkg::LSR_DR]) begin
            cause |= u8250_pkg::IIR_RDI;
        end
        if (ier_m[u8250_pkg::IER_THRI] && lsr_m[u8250_pkg::LSR_TEMT]) begin
            cause |= u8250_pkg::IIR_THRI;
        end
        iir_m = (cause != 4'h0) ? cause : u8250_pkg::IIR_NONE;
        irq_m = (cause != 4'h0);
        if (!ier_m[u8250_pkg::IER_THRI]) begin
            lsr_m[u8250_pkg::LSR_TEMT] = 1'b1;
            lsr_m[u8250_pkg::LSR_THRE] = 1'b1;
        end
        rep.irq = irq_m;
        return rep;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %02h actual %02h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic push_req(input u8250_pkg::t_kind kind, input logic [2:0] offset,
                            input logic [7:0] wdata, input logic [7:0] hbyte,
                            input logic first);
        t_uart_req r;
        r.kind        = kind;
        r.offset      = offset;
        r.wdata       = wdata;
        r.hbyte       = hbyte;
        r.burst_first = first;
        req_backlog.push_back(r);
    endtask

    // sets DLAB and loopback, with random content in the other bits
    task automatic push_mode(input logic dlab, input logic loop);
        push_req(u8250_pkg::KIND_WRITE, u8250_pkg::REG_LCR, {dlab, 7'($urandom)},
                 8'($urandom), 1'($urandom));
        push_req(u8250_pkg::KIND_WRITE, u8250_pkg::REG_MCR,
                 (8'($urandom) & ~LOOP_MASK) | (loop ? LOOP_MASK : 8'h00),
                 8'($urandom), 1'($urandom));
    endtask

    // random part: mostly well-formed sequences with random content, some noise
    task automatic queue_random(input int target);
        int stop_at;
        int pick;
        int n;
        int i;
        stop_at = req_backlog.size() + target;
        while (req_backlog.size() < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 28) begin
                // receive burst from the host, then drained by reads
                push_mode(1'b0, 1'b0);
                n = ($urandom_range(19) == 0)
                    ? $urandom_range(u8250_pkg::RX_DEPTH - 3, u8250_pkg::RX_DEPTH + 2)
                    : $urandom_range(1, 8);
                for (i = 0; i < n; i++) begin
                    push_req(u8250_pkg::KIND_HOST, 3'($urandom), 8'($urandom), 8'($urandom),
                             (i == 0) ^ ($urandom_range(15) == 0));
                    if ($urandom_range(7) == 0) begin
                        push_req(u8250_pkg::KIND_READ, u8250_pkg::REG_RBR, 8'($urandom),
                                 8'($urandom), 1'($urandom));
                    end
                end
                n = $urandom_range(0, n + 2);
                for (i = 0; i < n; i++) begin
                    push_req(u8250_pkg::KIND_READ,
                             ($urandom_range(5) == 0) ? u8250_pkg::REG_LSR : u8250_pkg::REG_RBR,
                             8'($urandom), 8'($urandom), 1'($urandom));
                end
            end else if (pick < 43) begin
                // loopback: written bytes come back through the receive buffer
                push_mode(1'b0, 1'b1);
                n = ($urandom_range(19) == 0)
                    ? $urandom_range(u8250_pkg::RX_DEPTH, u8250_pkg::RX_DEPTH + 2)
                    : $urandom_range(1, 6);
                for (i = 0; i < n; i++) begin
                    push_req(u8250_pkg::KIND_WRITE, u8250_pkg::REG_RBR, 8'($urandom),
                             8'($urandom), 1'($urandom));
                end
                if ($urandom_range(2) == 0) begin
                    push_req(u8250_pkg::KIND_HOST, 3'($urandom), 8'($urandom), 8'($urandom),
                             1'($urandom));
                end
                n = $urandom_range(0, n + 2);
                for (i = 0; i < n; i++) begin
                    push_req(u8250_pkg::KIND_READ, u8250_pkg::REG_RBR, 8'($urandom),
                             8'($urandom), 1'($urandom));
                end
                if ($urandom_range(1) == 0) begin
                    push_mode(1'b0, 1'b0);
                end
            end else if (pick < 55) begin
                // break injection, optionally after a receiver flush
                push_mode(1'b0, 1'b0);
                if ($urandom_range(1) == 0) begin
                    push_req(u8250_pkg::KIND_WRITE, u8250_pkg::REG_IIR,
                             8'($urandom) | FLUSH_RX_MASK, 8'($urandom), 1'($urandom));
                end
                push_req(u8250_pkg::KIND_BREAK, 3'($urandom), 8'($urandom),
                         ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom), 1'($urandom));
                n = $urandom_range(1, 3);
                for (i = 0; i < n; i++) begin
                    push_req(u8250_pkg::KIND_READ, u8250_pkg::REG_RBR, 8'($urandom),
                             8'($urandom), 1'($urandom));
                end
                if ($urandom_range(2) == 0) begin
                    push_req(u8250_pkg::KIND_HOST, 3'($urandom), 8'($urandom), 8'($urandom),
                             1'b1);
                end
            end else if (pick < 65) begin
                // divisor latch access
                push_mode(1'b1, 1'($urandom));
                push_req(u8250_pkg::KIND_WRITE, u8250_pkg::REG_RBR, 8'($urandom),
                         8'($urandom), 1'($urandom));
                push_req(u8250_pkg::KIND_WRITE, u8250_pkg::REG_IER, 8'($urandom),
                         8'($urandom), 1'($urandom));
                push_req(u8250_pkg::KIND_READ, u8250_pkg::REG_RBR, 8'($urandom),
                         8'($urandom), 1'($urandom));
                push_req(u8250_pkg::KIND_READ, u8250_pkg::REG_IER, 8'($urandom),
                         8'($urandom), 1'($urandom));
                push_req(u8250_pkg::KIND_WRITE, u8250_pkg::REG_LCR, 8'($urandom) & ~DLAB_MASK,
                         8'($urandom), 1'($urandom));
            end else if (pick < 78) begin
                // control register traffic at any offset
                n = $urandom_range(1, 4);
                for (i = 0; i < n; i++) begin
                    push_req($urandom_range(1) ? u8250_pkg::KIND_WRITE : u8250_pkg::KIND_READ,
                             3'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
                end
            end else begin
                // noise: anything at all
                n = $urandom_range(1, 4);
                for (i = 0; i < n; i++) begin
                    push_req(u8250_pkg::t_kind'($urandom_range(3)), 3'($urandom),
                             8'($urandom), 8'($urandom), 1'($urandom));
                end
            end
        end
    endtask

    // config write of the break injection enable, only while the block is idle
    task automatic write_break_enable(input logic value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // waits until every queued request went in and every reply came out
    task automatic wait_drained();
        do @(negedge i_clk);
        while (req_backlog.size() != 0 || i_in_valid || reply_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // request driver: holds the payload until taken, idles at random
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || req_taken) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_req = req_backlog.pop_front();
                i_in_valid        <= 1'b1;
                i_kind            <= next_req.kind;
                i_register_offset <= next_req.offset;
                i_write_data      <= next_req.wdata;
                i_host_byte       <= next_req.hbyte;
                i_burst_start     <= next_req.burst_first;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // reply side stall: a long hold-off at each phase start fills the block
    // and backs up the request channel, then random stalls
    always @(negedge i_clk) begin
        if (phase_id != held_phase) begin
            held_phase  <= phase_id;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // monitor: checks each reply against the oldest prediction, then predicts
    // the reply of a request taken at this edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dll_m     = 8'h00;
            dlm_m     = 8'h00;
            ier_m     = 4'h0;
            fcr_m     = 8'h00;
            lcr_m     = 8'h00;
            mcr_m     = u8250_pkg::MCR_RESET;
            lsr_m     = u8250_pkg::LSR_RESET;
            scr_m     = 8'h00;
            iir_m     = u8250_pkg::IIR_NONE;
            irq_m     = 1'b0;
            brk_en_m  = 1'b1;
            rx_fill_m = '0;
            rx_rd_m   = '0;
            req_taken <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got_rep = {o_read_data, o_access_claimed, o_tx_valid, o_tx_byte,
                           o_rx_accepted, o_irq_level};
                n_results++;
                if (reply_q.size() == 0) begin
                    $display("%0t: unexpected reply, expected none actual %h", $time, got_rep);
                    mismatches++;
                end else begin
                    want_rep = reply_q.pop_front();
                    check_field("read_data", want_rep.read_data, got_rep.read_data);
                    check_field("access_claimed", 8'(want_rep.claimed), 8'(got_rep.claimed));
                    check_field("tx_valid", 8'(want_rep.tx_valid), 8'(got_rep.tx_valid));
                    check_field("tx_byte", want_rep.tx_byte, got_rep.tx_byte);
                    check_field("rx_accepted", 8'(want_rep.rx_stored),
                                8'(got_rep.rx_stored));
                    check_field("irq_level", 8'(want_rep.irq), 8'(got_rep.irq));
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                brk_en_m = i_cfg_data;
            end
            if (i_in_valid && !o_in_stall) begin
                seen_req.kind        = u8250_pkg::t_kind'(i_kind);
                seen_req.offset      = i_register_offset;
                seen_req.wdata       = i_write_data;
                seen_req.hbyte       = i_host_byte;
                seen_req.burst_first = i_burst_start;
                want_rep = model_apply(seen_req);
                reply_q.push_back(want_rep);
                n_accepted++;
                n_stored += int'(want_rep.rx_stored);
                n_sent   += int'(want_rep.tx_valid);
                n_irq    += int'(want_rep.irq);
            end
            req_taken <= i_in_valid && !o_in_stall;
        end
    end

    // watchdog: gives up when no handshake happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d replies outstanding",
                         $time, stuck_cycles, reply_q.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    // sequencer: reset, then three pacing phases with config writes in between
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_break_enable(1'b1);

        // phase 1: sender idles a third of the time, receiver stalls most of it
        @(posedge i_clk);
        send_idle_pct = 34;
        recv_idle_pct = 87;
        phase_id      = 1;
        // directed corner cases first
        push_req(u8250_pkg::KIND_READ,  u8250_pkg::REG_LSR, 8'h00, 8'h00, 1'b0); // reset status
        push_req(u8250_pkg::KIND_READ,  u8250_pkg::REG_RBR, 8'h00, 8'h00, 1'b0); // empty rx
        push_req(u8250_pkg::KIND_WRITE, u8250_pkg::REG_SCR, 8'hFF, 8'h00, 1'b0);
        push_req(u8250_pkg::KIND_READ,  u8250_pkg::REG_SCR, 8'h00, 8'hFF, 1'b1);
        push_req(u8250_pkg::KIND_WRITE, u8250_pkg::REG_LSR, 8'hFF, 8'hFF, 1'b1); // not claimed
        push_req(u8250_pkg::KIND_WRITE, u8250_pkg::REG_MSR, 8'h00, 8'h00, 1'b0); // not claimed
        push_req(u8250_pkg::KIND_WRITE, u8250_pkg::REG_RBR, 8'hFF, 8'h00, 1'b0); // transmit
        push_req(u8250_pkg::KIND_WRITE, u8250_pkg::REG_LCR, DLAB_MASK, 8'h00, 1'b0);
        push_req(u8250_pkg::KIND_WRITE, u8250_pkg::REG_RBR, 8'hA5, 8'h00, 1'b0); // divisor low
        push_req(u8250_pkg::KIND_WRITE, u8250_pkg::REG_IER, 8'h5A, 8'h00, 1'b0); // divisor high
        push_req(u8250_pkg::KIND_READ,  u8250_pkg::REG_IER, 8'h00, 8'h00, 1'b0);
        push_req(u8250_pkg::KIND_WRITE, u8250_pkg::REG_LCR, 8'h03, 8'h00, 1'b0);
        push_req(u8250_pkg::KIND_WRITE, u8250_pkg::REG_IER, 8'hFF, 8'h00, 1'b0); // all causes
        push_req(u8250_pkg::KIND_HOST,  u8250_pkg::REG_RBR, 8'h00, 8'hFF, 1'b1); // burst opens
        push_req(u8250_pkg::KIND_HOST,  u8250_pkg::REG_RBR, 8'h00, 8'h00, 1'b0);
        push_req(u8250_pkg::KIND_HOST,  u8250_pkg::REG_SCR, 8'h00, 8'h11, 1'b1); // data ready
        push_req(u8250_pkg::KIND_READ,  u8250_pkg::REG_RBR, 8'h00, 8'h00, 1'b0);
        push_req(u8250_pkg::KIND_READ,  u8250_pkg::REG_RBR, 8'h00, 8'h00, 1'b0); // last byte
        push_req(u8250_pkg::KIND_HOST,  u8250_pkg::REG_RBR, 8'h00, 8'h22, 1'b0); // empty
        push_req(u8250_pkg::KIND_BREAK, u8250_pkg::REG_RBR, 8'h00, 8'h00, 1'b0); // zero value
        push_req(u8250_pkg::KIND_BREAK, u8250_pkg::REG_RBR, 8'h00, 8'h7E, 1'b0);
        push_req(u8250_pkg::KIND_READ,  u8250_pkg::REG_RBR, 8'h00, 8'h00, 1'b0); // break zero
        push_req(u8250_pkg::KIND_READ,  u8250_pkg::REG_RBR, 8'h00, 8'h00, 1'b0); // stored byte
        push_req(u8250_pkg::KIND_WRITE, u8250_pkg::REG_MCR, u8250_pkg::MCR_RESET | LOOP_MASK,
                 8'h00, 1'b0);
        push_req(u8250_pkg::KIND_HOST,  u8250_pkg::REG_RBR, 8'h00, 8'h33, 1'b1); // in loopback
        push_req(u8250_pkg::KIND_WRITE, u8250_pkg::REG_RBR, 8'h3C, 8'h00, 1'b0); // looped back
        push_req(u8250_pkg::KIND_WRITE, u8250_pkg::REG_IIR, FLUSH_RX_MASK | FLUSH_TX_MASK,
                 8'h00, 1'b0);
        queue_random(RANDOM_ITEMS);
        wait_drained();
        write_break_enable(1'b0);

        // phase 2: roles swapped, breaks now refused
        @(posedge i_clk);
        send_idle_pct = 87;
        recv_idle_pct = 34;
        phase_id      = 2;
        queue_random(RANDOM_ITEMS);
        wait_drained();
        write_break_enable(1'b1);

        // phase 3: back to back, no random idling on either side
        @(posedge i_clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        phase_id      = 3;
        queue_random(RANDOM_ITEMS);
        wait_drained();

        $display("ran %0d requests over three pacing phases, %0d replies checked",
                 n_accepted, n_results);
        $display("receive buffer took %0d bytes, %0d bytes sent, irq high in %0d replies",
                 n_stored, n_sent, n_irq);
        if (mismatches == 0 && reply_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
